/* hdl/metsig_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metsig_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package metsig_pkg;

  localparam int MAG_W   = 16;
  localparam int ANG_W   = 16;
  localparam int COV_W   = 32;
  localparam int SIG_W   = 24;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int ANGLE_ITERATIONS_MAX = 24;

  // 1/K in Q30
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  localparam int Q_W = 48;
  localparam logic [SIG_W-1:0] SIG_SAT = '1;

  // atan(2^-i) in LSB pi/2^31
  function automatic logic signed [32:0] atan_lsb(input int i);
    logic signed [32:0] v;
    case (i)
      0:  v = 33'sd536870912;
      1:  v = 33'sd316933406;
      2:  v = 33'sd167458907;
      3:  v = 33'sd85004756;
      4:  v = 33'sd42667331;
      5:  v = 33'sd21354465;
      6:  v = 33'sd10679838;
      7:  v = 33'sd5340245;
      8:  v = 33'sd2670163;
      9:  v = 33'sd1335087;
      10: v = 33'sd667544;
      11: v = 33'sd333772;
      12: v = 33'sd166886;
      13: v = 33'sd83443;
      14: v = 33'sd41722;
      15: v = 33'sd20861;
      16: v = 33'sd10430;
      17: v = 33'sd5215;
      18: v = 33'sd2608;
      19: v = 33'sd1304;
      20: v = 33'sd652;
      21: v = 33'sd326;
      22: v = 33'sd163;
      23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/metsig_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metsig_in_if
// Missing-energy record channel: magnitude, angle and covariance.
// ----------------------------------------------------------------------------
interface metsig_in_if;
  logic valid;
  logic ready;
  logic        [metsig_pkg::MAG_W-1:0] met_magnitude;
  logic signed [metsig_pkg::ANG_W-1:0] met_angle;
  logic signed [metsig_pkg::COV_W-1:0] cov_xx;
  logic signed [metsig_pkg::COV_W-1:0] cov_xy;
  logic signed [metsig_pkg::COV_W-1:0] cov_yx;
  logic signed [metsig_pkg::COV_W-1:0] cov_yy;

  modport source (output valid, met_magnitude, met_angle, cov_xx, cov_xy, cov_yx, cov_yy,
                  input ready);
  modport sink (input valid, met_magnitude, met_angle, cov_xx, cov_xy, cov_yx, cov_yy,
                output ready);
endinterface
`default_nettype wire

/* hdl/metsig_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metsig_out_if
// Significance result channel.
// ----------------------------------------------------------------------------
interface metsig_out_if;
  logic valid;
  logic ready;
  logic [metsig_pkg::SIG_W-1:0] significance;
  logic singular;
  logic invalid;

  modport source (output valid, significance, singular, invalid, input ready);
  modport sink (input valid, significance, singular, invalid, output ready);
endinterface
`default_nettype wire

/* hdl/met_significance_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_significance_unit
// Pipelined MET significance: CORDIC sin/cos, quadratic form with inverse
// covariance (covariance if singular), restoring divide, integer square root.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  rec     | in  | met_magnitude, met_angle, cov_xx, cov_xy, cov_yx, cov_yy
//  res     | out | significance, singular, invalid
//
//  One item per cycle while res keeps taking results (one CORDIC step, one
//  quotient bit and one root bit per stage).
//  Whole pipeline advances together; it stalls only when the last stage holds
//  an item that res does not take. Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
module met_significance_unit #(
  parameter int ANGLE_ITERATIONS = metsig_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  metsig_in_if.sink   rec,
  metsig_out_if.source res
);

  localparam int IT = ANGLE_ITERATIONS;
  localparam int QW = metsig_pkg::Q_W;
  localparam int NW = 90;
  localparam int SW = 112;
  localparam int RN = QW / 2;

  typedef struct packed {
    logic [15:0]        m;
    logic signed [31:0] cxx;
    logic signed [31:0] cxy;
    logic signed [31:0] cyx;
    logic signed [31:0] cyy;
    logic               flip;
  } side_t;

  typedef struct packed {
    logic          sing;
    logic          zero;
    logic          inv;
    logic          sat;
    logic [QW-1:0] qs;
    logic [63:0]   ud;
  } dcar_t;

  typedef struct packed {
    logic sing;
    logic zero;
    logic inv;
    logic sat;
  } flags_t;

  logic en;
  logic iv [0:RN];

  assign en = !iv[RN] || res.ready;
  assign rec.ready = en;

  // ---------------- fold and CORDIC ----------------
  logic               cv [0:IT];
  logic signed [32:0] cx [0:IT];
  logic signed [32:0] cy [0:IT];
  logic signed [32:0] cz [0:IT];
  side_t              cs [0:IT];

  logic signed [16:0] af;
  logic               flip0;

  always_comb begin
    af = 17'(rec.met_angle);
    flip0 = 1'b0;
    if (rec.met_angle > 16'sd16384) begin
      af = 17'(rec.met_angle) - 17'sd32768;
      flip0 = 1'b1;
    end else if (rec.met_angle < -16'sd16384) begin
      af = 17'(rec.met_angle) + 17'sd32768;
      flip0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (en) cv[0] <= rec.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= metsig_pkg::CORDIC_X0;
      cy[0] <= '0;
      cz[0] <= 33'(af) <<< 16;
      cs[0] <= '{m: rec.met_magnitude, cxx: rec.cov_xx, cxy: rec.cov_xy,
                 cyx: rec.cov_yx, cyy: rec.cov_yy, flip: flip0};
    end
  end

  for (genvar g = 0; g < IT; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) cv[g+1] <= 1'b0;
      else if (en) cv[g+1] <= cv[g];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cs[g+1] <= cs[g];
        if (cz[g] >= 0) begin
          cx[g+1] <= cx[g] - (cy[g] >>> g);
          cy[g+1] <= cy[g] + (cx[g] >>> g);
          cz[g+1] <= cz[g] - metsig_pkg::atan_lsb(g);
        end else begin
          cx[g+1] <= cx[g] + (cy[g] >>> g);
          cy[g+1] <= cy[g] - (cx[g] >>> g);
          cz[g+1] <= cz[g] + metsig_pkg::atan_lsb(g);
        end
      end
    end
  end

  // ---------------- px/py, determinant, quadratic form ----------------
  logic v_f, v_m, v_r, v_p, v_q, v_t, v_s, v_a;

  logic signed [32:0] fx, fy;
  logic signed [63:0] dp0, dp1;
  side_t              fs;

  logic signed [49:0] mx, my;
  logic signed [63:0] md;
  side_t              ms;

  logic signed [26:0] px, py;
  logic signed [63:0] rd;
  logic               rdnz;
  side_t              rs;

  logic signed [51:0] op [0:2];
  logic signed [32:0] cf [0:2];
  logic signed [63:0] pd;
  logic               pdnz;

  logic signed [59:0] plo [0:2];
  logic signed [59:0] phi [0:2];
  logic signed [63:0] qd;
  logic               qdnz;

  logic signed [NW-1:0] tt [0:2];
  logic signed [63:0]   td;
  logic                 tdnz;

  logic signed [NW-1:0] sn;
  logic signed [63:0]   sd;
  logic                 sdnz;

  logic [NW-1:0] an;
  logic          a_sat_s;
  dcar_t         ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0; v_m <= 1'b0; v_r <= 1'b0; v_p <= 1'b0;
      v_q <= 1'b0; v_t <= 1'b0; v_s <= 1'b0; v_a <= 1'b0;
    end else if (en) begin
      v_f <= cv[IT]; v_m <= v_f; v_r <= v_m; v_p <= v_r;
      v_q <= v_p; v_t <= v_q; v_s <= v_t; v_a <= v_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // undo the fold
      fx  <= cs[IT].flip ? -cx[IT] : cx[IT];
      fy  <= cs[IT].flip ? -cy[IT] : cy[IT];
      dp0 <= 64'(cs[IT].cxx) * 64'(cs[IT].cyy);
      dp1 <= 64'(cs[IT].cxy) * 64'(cs[IT].cyx);
      fs  <= cs[IT];

      mx <= 50'($signed({1'b0, fs.m})) * 50'(fx);
      my <= 50'($signed({1'b0, fs.m})) * 50'(fy);
      md <= dp0 - dp1;
      ms <= fs;

      // round to nearest, ties up
      px   <= 27'((mx + 50'sd2097152) >>> 22);
      py   <= 27'((my + 50'sd2097152) >>> 22);
      rd   <= md;
      rdnz <= md != 64'sd0;
      rs   <= ms;

      op[0] <= 52'(54'(px) * 54'(px));
      op[1] <= 52'((54'(px) * 54'(py)) <<< 1);
      op[2] <= 52'(54'(py) * 54'(py));
      cf[0] <= rdnz ? 33'(rs.cyy) : 33'(rs.cxx);
      cf[1] <= rdnz ? -33'(rs.cyx) : 33'(rs.cyx);
      cf[2] <= rdnz ? 33'(rs.cxx) : 33'(rs.cyy);
      pd    <= rd;
      pdnz  <= rdnz;

      for (int k = 0; k < 3; k++) begin
        plo[k] <= 60'($signed({1'b0, op[k][25:0]})) * 60'(cf[k]);
        phi[k] <= 60'($signed(op[k][51:26])) * 60'(cf[k]);
      end
      qd   <= pd;
      qdnz <= pdnz;

      for (int k = 0; k < 3; k++) begin
        tt[k] <= (NW'(phi[k]) <<< 26) + NW'(plo[k]);
      end
      td   <= qd;
      tdnz <= qdnz;

      sn   <= tt[0] + tt[1] + tt[2];
      sd   <= td;
      sdnz <= tdnz;

      an         <= sn[NW-1] ? NW'(-sn) : NW'(sn);
      a_sat_s    <= sn[NW-1:56] != '0;
      ac.sing    <= !sdnz;
      ac.zero    <= sn == '0;
      ac.inv     <= (sn != '0) && (sdnz ? (sn[NW-1] != sd[63]) : sn[NW-1]);
      ac.sat     <= 1'b0;
      ac.qs      <= sn[55:8];
      ac.ud      <= sd[63] ? 64'(-sd) : 64'(sd);
    end
  end

  // ---------------- restoring divide, one quotient bit per stage ----------------
  logic            dv [0:QW];
  logic [NW-1:0]   rem [0:QW];
  logic [QW-1:0]   qd_bits [0:QW];
  dcar_t           dc [0:QW];
  dcar_t           dc0;

  always_comb begin
    dc0     = ac;
    dc0.sat = ac.sing ? a_sat_s : (SW'(an) >= {ac.ud, {QW{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]     <= an;
      qd_bits[0] <= '0;
      dc[0]      <= dc0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [SW-1:0] sh;
    assign sh = SW'(dc[j].ud) << (QW - 1 - j);
    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dc[j+1] <= dc[j];
        if (SW'(rem[j]) >= sh) begin
          rem[j+1]     <= rem[j] - NW'(sh);
          qd_bits[j+1] <= qd_bits[j] | (QW'(1) << (QW - 1 - j));
        end else begin
          rem[j+1]     <= rem[j];
          qd_bits[j+1] <= qd_bits[j];
        end
      end
    end
  end

  // ---------------- integer square root, one root bit per stage ----------------
  logic [QW:0]   rv [0:RN];
  logic [QW-1:0] rr [0:RN];
  flags_t        ic [0:RN];

  always_ff @(posedge clk) begin
    if (rst) iv[0] <= 1'b0;
    else if (en) iv[0] <= dv[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rv[0] <= dc[QW].sing ? (QW+1)'(dc[QW].qs) : (QW+1)'(qd_bits[QW]);
      rr[0] <= '0;
      ic[0] <= '{sing: dc[QW].sing, zero: dc[QW].zero, inv: dc[QW].inv, sat: dc[QW].sat};
    end
  end

  for (genvar k = 0; k < RN; k++) begin : g_root
    logic [QW:0] rb;
    assign rb = (QW+1)'(rr[k]) + ((QW+1)'(1) << (QW - 2 - 2*k));
    always_ff @(posedge clk) begin
      if (rst) iv[k+1] <= 1'b0;
      else if (en) iv[k+1] <= iv[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ic[k+1] <= ic[k];
        if (rv[k] >= rb) begin
          rv[k+1] <= rv[k] - rb;
          rr[k+1] <= (rr[k] >> 1) + (QW'(1) << (QW - 2 - 2*k));
        end else begin
          rv[k+1] <= rv[k];
          rr[k+1] <= rr[k] >> 1;
        end
      end
    end
  end

  assign res.valid        = iv[RN];
  assign res.singular     = ic[RN].sing;
  assign res.invalid      = ic[RN].inv;
  assign res.significance = (ic[RN].zero || ic[RN].inv) ? '0 :
                            ic[RN].sat ? metsig_pkg::SIG_SAT :
                            rr[RN][metsig_pkg::SIG_W-1:0];

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.invalid |-> res.significance == '0)
    else $error("invalid item with nonzero significance");

  a_zero_valid: assert property (@(posedge clk) disable iff (rst)
    iv[RN] && ic[RN].zero |-> !res.invalid)
    else $error("zero form flagged invalid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid && !dv[0] && !cv[0])
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

/* tb/met_significance_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// met_significance_unit_tb
// Drives missing-energy records into the significance unit and checks every
// result against an integer model of the CORDIC, inverse-covariance form,
// division and square root. A directed table comes first, then random records
// under changing backpressure.
// ----------------------------------------------------------------------------
module met_significance_unit_tb;

  localparam int ANG_IT      = metsig_pkg::ANGLE_ITERATIONS_DEF;
  localparam int SIG_BITS    = metsig_pkg::SIG_W;
  localparam int LATENCY     = ANG_IT + 83;
  localparam int N_RANDOM    = 600;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        [metsig_pkg::MAG_W-1:0] mag;
    logic signed [metsig_pkg::ANG_W-1:0] ang;
    logic signed [metsig_pkg::COV_W-1:0] cxx, cxy, cyx, cyy;
  } met_rec_t;

  typedef struct {
    logic [metsig_pkg::SIG_W-1:0] sig;
    logic                         sing;
    logic                         inv;
  } sig_res_t;

  typedef struct {
    met_rec_t rec;
    bit       typed;
    sig_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  metsig_in_if  rec_if ();
  metsig_out_if res_if ();

  met_significance_unit #(.ANGLE_ITERATIONS(ANG_IT)) u_top (
    .clk (clk),
    .rst (rst),
    .rec (rec_if),
    .res (res_if)
  );

  sig_res_t sig_expected_q[$];
  int       n_fail = 0;
  int       snd_idle_pct = 30;
  int       rcv_idle_pct = 46;
  longint   cycle_cnt = 0;

  // atan(2^-i), LSB pi/2^31
  longint atan_lut[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 46;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic sig_res_t predict_sig(met_rec_t r);
    longint a, x, y, z, t, px, py, qq;
    bit flip;
    logic signed [127:0] cxx, cxy, cyx, cyy, d, n, p, q, un, ud;
    sig_res_t o;
    a = r.ang;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    o = '{sig: '0, sing: 1'b0, inv: 1'b0};
    if (a > 16384) begin
      a = a - 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a = a + 32768;
      flip = 1'b1;
    end
    z = a * 65536;
    for (int i = 0; i < ANG_IT && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - atan_lut[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + atan_lut[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = (longint'({48'b0, r.mag}) * x + (64'sd1 <<< 21)) >>> 22;
    py = (longint'({48'b0, r.mag}) * y + (64'sd1 <<< 21)) >>> 22;
    cxx = r.cxx; cxy = r.cxy; cyx = r.cyx; cyy = r.cyy;
    p = px;
    q = py;
    d = cxx * cyy - cxy * cyx;
    if (d != 0) begin
      n = p * p * cyy - 2 * p * q * cyx + q * q * cxx;
    end else begin
      o.sing = 1'b1;
      n = p * p * cxx + 2 * p * q * cyx + q * q * cyy;
    end
    if (n == 0) begin
      o.sig = '0;
    end else if (d != 0) begin
      if ((n < 0) != (d < 0)) begin
        o.inv = 1'b1;
      end else begin
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un >= (ud <<< 48)) begin
          o.sig = metsig_pkg::SIG_SAT;
        end else begin
          qq = longint'(un / ud);
          o.sig = SIG_BITS'(root_floor(qq));
        end
      end
    end else if (n < 0) begin
      o.inv = 1'b1;
    end else begin
      n = n >>> 8;
      if (n >= (128'sd1 <<< 48)) o.sig = metsig_pkg::SIG_SAT;
      else o.sig = SIG_BITS'(root_floor(longint'(n)));
    end
    return o;
  endfunction

  // accepted records -> expectations
  always @(posedge clk) begin
    sig_res_t p;
    if (!rst && rec_if.valid && rec_if.ready) begin
      p = predict_sig(met_rec_t'{mag: rec_if.met_magnitude, ang: rec_if.met_angle,
          cxx: rec_if.cov_xx, cxy: rec_if.cov_xy, cyx: rec_if.cov_yx, cyy: rec_if.cov_yy});
      sig_expected_q = {sig_expected_q, p};
    end
  end

  always @(posedge clk) begin
    sig_res_t e;
    if (!rst && res_if.valid && res_if.ready) begin
      if (sig_expected_q.size() == 0) begin
        $error("result with nothing expected: significance %0h", res_if.significance);
        n_fail++;
      end else begin
        e = sig_expected_q.pop_front();
        if (res_if.significance !== e.sig) begin
          $error("significance expected %0h actual %0h", e.sig, res_if.significance);
          n_fail++;
        end
        if (res_if.singular !== e.sing) begin
          $error("singular expected %0b actual %0b", e.sing, res_if.singular);
          n_fail++;
        end
        if (res_if.invalid !== e.inv) begin
          $error("invalid expected %0b actual %0b", e.inv, res_if.invalid);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_rec(met_rec_t r);
    rec_if.valid         <= 1'b1;
    rec_if.met_magnitude <= r.mag;
    rec_if.met_angle     <= r.ang;
    rec_if.cov_xx        <= r.cxx;
    rec_if.cov_xy        <= r.cxy;
    rec_if.cov_yx        <= r.cyx;
    rec_if.cov_yy        <= r.cyy;
    do @(posedge clk); while (!rec_if.ready);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      rec_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic met_rec_t rand_rec();
    met_rec_t r;
    int s, k;
    r.mag = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 255)) : 16'($urandom);
    r.ang = 16'($urandom);
    k = $urandom_range(0, 9);
    case (k)
      0, 1: begin  // full range
        r.cxx = $urandom; r.cxy = $urandom; r.cyx = $urandom; r.cyy = $urandom;
      end
      2, 3: begin  // rank-one matrix, determinant zero
        s = $signed($urandom_range(0, 64)) - 32;
        r.cxx = $signed($urandom_range(0, 8191)) - 4096;
        r.cyx = $signed($urandom_range(0, 8191)) - 4096;
        r.cxy = r.cxx * s;
        r.cyy = r.cyx * s;
      end
      4: begin
        r.cxx = 0; r.cxy = 0; r.cyx = 0; r.cyy = 0;
      end
      default: begin  // covariance-like, modest size
        r.cxx = $urandom_range(0, 1 << 20);
        r.cyy = $urandom_range(0, 1 << 20);
        r.cxy = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
        r.cyx = ($urandom_range(0, 1)) ? r.cxy : $signed($urandom_range(0, 1 << 16)) - (1 << 15);
        if ($urandom_range(0, 7) == 0) r.cxx = -r.cxx;
      end
    endcase
    return r;
  endfunction

  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;

  dir_row_t dir_tab[] = '{
    '{'{16'd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '{24'd0, 1'b1, 1'b0}},
    '{'{16'd0, 16'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1}, 1, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd100, 16'sd0, -32'sd1, 32'sd0, 32'sd0, -32'sd1}, 1, '{24'd0, 1'b0, 1'b1}},
    '{'{16'd100, 16'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd0}, 1, '{24'd0, 1'b1, 1'b1}},
    '{'{16'hFFFF, 16'sd0, CMAX, 32'sd0, 32'sd0, 32'sd0}, 1, '{24'hFFFFFF, 1'b1, 1'b0}},
    '{'{16'hFFFF, 16'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd1}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'hFFFF, 16'sh7FFF, 32'sd16, 32'sd3, 32'sd3, 32'sd16}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'hFFFF, 16'sh8000, 32'sd16, 32'sd3, 32'sd3, 32'sd16}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd4000, 16'sd16384, 32'sd256, -32'sd5, -32'sd5, 32'sd64}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd4000, -16'sd16384, 32'sd256, -32'sd5, -32'sd5, 32'sd64}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd4000, 16'sd16385, 32'sd256, 32'sd7, 32'sd9, 32'sd64}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd4000, -16'sd16385, 32'sd256, 32'sd7, 32'sd9, 32'sd64}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd1234, 16'sd8192, CMAX, CMAX, CMAX, CMAX}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd1234, -16'sd8192, CMIN, CMIN, CMIN, CMIN}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'hFFFF, 16'sd5000, CMIN, CMAX, CMIN, CMIN}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'hFFFF, 16'sd5000, CMAX, CMIN, CMAX, CMAX}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd1, 16'sd1, 32'sd2, 32'sd1, 32'sd1, 32'sd2}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd800, 16'sd3000, 32'sd0, 32'sd1, 32'sd1, 32'sd0}, 0, '{24'd0, 1'b0, 1'b0}},
    '{'{16'd800, -16'sd3000, 32'sd4, 32'sd2, 32'sd2, 32'sd1}, 0, '{24'd0, 1'b0, 1'b0}}
  };

  initial begin
    sig_res_t e;
    rec_if.valid = 1'b0;
    rec_if.met_magnitude = '0;
    rec_if.met_angle = '0;
    rec_if.cov_xx = '0;
    rec_if.cov_xy = '0;
    rec_if.cov_yx = '0;
    rec_if.cov_yy = '0;
    res_if.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].typed) begin
        e = predict_sig(dir_tab[i].rec);
        // typed rows double as a sanity check of the predictor itself
        if (e.sig !== dir_tab[i].res.sig || e.sing !== dir_tab[i].res.sing ||
            e.inv !== dir_tab[i].res.inv) begin
          $error("table row %0d: expected %0h/%0b/%0b actual %0h/%0b/%0b", i,
                 dir_tab[i].res.sig, dir_tab[i].res.sing, dir_tab[i].res.inv,
                 e.sig, e.sing, e.inv);
          n_fail++;
        end
      end
      send_rec(dir_tab[i].rec);
    end

    // hold off until the pipeline has drained
    rec_if.valid <= 1'b0;
    while (sig_expected_q.size() != 0) @(posedge clk);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        snd_idle_pct = 46;
        rcv_idle_pct = 30;
      end else if (k == 2 * N_RANDOM / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      send_rec(rand_rec());
    end
    rec_if.valid <= 1'b0;

    while (sig_expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
